// ===== sv/template_string_comment_lexer_defines.svh =====
// Assertion helpers for the lexer back end.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef TEMPLATE_STRING_COMMENT_LEXER_DEFINES_SVH
`define TEMPLATE_STRING_COMMENT_LEXER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSCL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSCL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tscl_pkg.sv =====
`timescale 1ns / 1ps

package tscl_pkg;

  // Width of the comment nesting depth counter.
  localparam int DEPTH_BITS = 16;

  // Queue between the front and the back.
  localparam int QAW    = 2;
  localparam int QDEPTH = 1 << QAW;

  // Token kind bits in valid_kinds.
  localparam int KB_STRING  = 0;
  localparam int KB_HEAD    = 1;
  localparam int KB_SPAN    = 2;
  localparam int KB_TAIL    = 3;
  localparam int KB_COMMENT = 4;

  // Result status codes.
  localparam logic [1:0] ST_ACCEPT   = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Result token kinds.
  localparam logic [2:0] TK_STRING  = 3'd0;
  localparam logic [2:0] TK_HEAD    = 3'd1;
  localparam logic [2:0] TK_SPAN    = 3'd2;
  localparam logic [2:0] TK_TAIL    = 3'd3;
  localparam logic [2:0] TK_COMMENT = 3'd4;

  // Character classes produced by the front.
  typedef enum logic [3:0] {
    CC_EOF,
    CC_BLANK,
    CC_NEWLINE,
    CC_QUOTE,
    CC_RBRACE,
    CC_LBRACE,
    CC_SLASH,
    CC_STAR,
    CC_BSLASH,
    CC_DOLLAR,
    CC_OTHER
  } chcls_t;

  typedef struct packed {
    logic       start_req;
    logic [4:0] valid_kinds;
    logic [7:0] ch;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] token_kind;
    logic       taken;
  } out_item_t;

  // One classified character as it travels through the queue.
  typedef struct packed {
    logic       start;
    logic [4:0] kinds;
    chcls_t     cls;
  } q_item_t;

endpackage

// ===== sv/tscl_front.sv =====
`timescale 1ns / 1ps

module tscl_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  tscl_pkg::in_item_t in_item,
  output logic               q_wr,
  output tscl_pkg::q_item_t  q_item,
  input  logic               q_full
);
  import tscl_pkg::*;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  function automatic chcls_t classify(input logic [7:0] c, input logic eof);
    chcls_t r;
    if (eof) begin
      r = CC_EOF;
    end else begin
      case (c)
        CH_NL:                    r = CC_NEWLINE;
        CH_SPACE, CH_TAB, CH_CR:  r = CC_BLANK;
        CH_QUOTE:                 r = CC_QUOTE;
        CH_RBRACE:                r = CC_RBRACE;
        CH_LBRACE:                r = CC_LBRACE;
        CH_SLASH:                 r = CC_SLASH;
        CH_STAR:                  r = CC_STAR;
        CH_BSLASH:                r = CC_BSLASH;
        CH_DOLLAR:                r = CC_DOLLAR;
        default:                  r = CC_OTHER;
      endcase
    end
    return r;
  endfunction

  logic    stage_valid_r, stage_valid_nxt;
  q_item_t stage_item_r;
  logic    accept;

  // The stage holds only while the queue is full.
  assign in_full = stage_valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_wr    = stage_valid_r && !q_full;
  assign q_item  = stage_item_r;

  assign stage_valid_nxt = accept || in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
    if (accept) begin
      stage_item_r.start <= in_item.start_req;
      stage_item_r.kinds <= in_item.valid_kinds;
      stage_item_r.cls   <= classify(in_item.ch, in_item.end_of_input);
    end
  end

endmodule

// ===== sv/tscl_queue.sv =====
`timescale 1ns / 1ps

module tscl_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  tscl_pkg::q_item_t wr_item,
  output logic              full,
  input  logic              rd,
  output tscl_pkg::q_item_t rd_item,
  output logic              nonempty
);
  import tscl_pkg::*;

  localparam logic [QAW:0] CNT_FULL = (QAW + 1)'(QDEPTH);

  q_item_t        slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_wr, do_rd;

  assign full     = (cnt_r == CNT_FULL);
  assign nonempty = (cnt_r != '0);
  assign rd_item  = slot_r[rd_ptr_r];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && nonempty;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ===== sv/tscl_back.sv =====
`timescale 1ns / 1ps

`include "template_string_comment_lexer_defines.svh"

module tscl_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_nonempty,
  input  tscl_pkg::q_item_t   q_item,
  output logic                q_rd,
  output logic                out_empty,
  input  logic                out_pop,
  output tscl_pkg::out_item_t out_item
);
  import tscl_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE,
    M_SKIP,
    M_BODY,
    M_ESC,
    M_DOLLAR,
    M_COPEN,
    M_CMT,
    M_CSLASH,
    M_CSTAR
  } mode_t;

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
  localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

  function automatic out_item_t mk_res(input logic [1:0] st, input logic [2:0] tk,
                                       input logic tkn);
    out_item_t r;
    r.status     = st;
    r.token_kind = tk;
    r.taken      = tkn;
    return r;
  endfunction

  mode_t                 mode_r, mode_nxt, m;
  logic [4:0]            kinds_r, kinds_nxt;
  logic                  brace_r, brace_nxt;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt, depth_dec;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r;
  logic                  res_valid;
  out_item_t             res;
  chcls_t                cls;
  logic                  go;

  // The back advances whenever a character waits and the result slot is free or
  // being drained in this cycle.
  assign go        = q_nonempty && (!out_valid_r || out_pop);
  assign q_rd      = go;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;
  assign cls       = q_item.cls;
  assign depth_dec = depth_r - 1'b1;

  always_comb begin
    mode_nxt  = mode_r;
    kinds_nxt = kinds_r;
    brace_nxt = brace_r;
    depth_nxt = depth_r;
    res_valid = 1'b0;
    res       = mk_res(ST_REJECT, TK_STRING, 1'b0);
    m         = mode_r;

    if (q_item.start) begin
      kinds_nxt = q_item.kinds;
      brace_nxt = 1'b0;
      depth_nxt = '0;
      m         = (q_item.kinds == '0) ? M_IDLE : M_SKIP;
      res_valid = (q_item.kinds == '0);
    end

    // A lone dollar, slash or star falls back to body or comment text, and the
    // same character is then handled in that mode.
    if (m == M_DOLLAR && cls != CC_LBRACE) begin
      m = M_BODY;
    end else if (m == M_CSLASH && cls != CC_STAR) begin
      m = M_CMT;
    end else if (m == M_CSTAR && cls != CC_SLASH) begin
      m = M_CMT;
    end

    case (m)
      M_IDLE: begin
        mode_nxt = M_IDLE;
      end
      M_SKIP: begin
        mode_nxt = M_SKIP;
        if (cls inside {CC_BLANK, CC_NEWLINE}) begin
          mode_nxt = M_SKIP;
        end else if (cls == CC_RBRACE && (kinds_nxt[KB_SPAN] || kinds_nxt[KB_TAIL])) begin
          brace_nxt = 1'b1;
          mode_nxt  = M_BODY;
        end else if (cls == CC_QUOTE && (kinds_nxt[KB_STRING] || kinds_nxt[KB_HEAD])) begin
          brace_nxt = 1'b0;
          mode_nxt  = M_BODY;
        end else if (cls == CC_SLASH && kinds_nxt[KB_COMMENT]) begin
          mode_nxt = M_COPEN;
        end else begin
          res_valid = 1'b1;
        end
      end
      M_BODY: begin
        mode_nxt = M_BODY;
        if (cls inside {CC_EOF, CC_NEWLINE}) begin
          res_valid = 1'b1;
        end else if (cls == CC_BSLASH) begin
          mode_nxt = M_ESC;
        end else if (cls == CC_QUOTE) begin
          res_valid = 1'b1;
          if (brace_nxt) begin
            res = mk_res(ST_ACCEPT, TK_TAIL, 1'b1);
          end else if (kinds_nxt[KB_STRING]) begin
            res = mk_res(ST_ACCEPT, TK_STRING, 1'b1);
          end else begin
            res = mk_res(ST_REJECT, TK_STRING, 1'b1);
          end
        end else if (cls == CC_DOLLAR) begin
          mode_nxt = M_DOLLAR;
        end
      end
      M_ESC: begin
        mode_nxt  = M_BODY;
        res_valid = (cls == CC_EOF);
      end
      M_DOLLAR: begin
        // Only reached with an opening brace: the hole closes the text.
        res_valid = 1'b1;
        if (brace_nxt) begin
          res = mk_res(ST_ACCEPT, TK_SPAN, 1'b1);
        end else if (kinds_nxt[KB_HEAD]) begin
          res = mk_res(ST_ACCEPT, TK_HEAD, 1'b1);
        end else begin
          res = mk_res(ST_REJECT, TK_STRING, 1'b1);
        end
      end
      M_COPEN: begin
        if (cls == CC_STAR) begin
          depth_nxt = DEPTH_ONE;
          mode_nxt  = M_CMT;
        end else begin
          res_valid = 1'b1;
        end
      end
      M_CMT: begin
        mode_nxt = M_CMT;
        if (cls == CC_EOF) begin
          res_valid = 1'b1;
        end else if (cls == CC_SLASH) begin
          mode_nxt = M_CSLASH;
        end else if (cls == CC_STAR) begin
          mode_nxt = M_CSTAR;
        end
      end
      M_CSLASH: begin
        // Only reached with a star: a nested opener.
        if (depth_nxt == DEPTH_MAX) begin
          res_valid = 1'b1;
          res       = mk_res(ST_OVERFLOW, TK_COMMENT, 1'b1);
        end else begin
          depth_nxt = depth_nxt + 1'b1;
          mode_nxt  = M_CMT;
        end
      end
      M_CSTAR: begin
        // Only reached with a slash: a closer.
        depth_nxt = depth_dec;
        if (depth_dec == '0) begin
          res_valid = 1'b1;
          res       = mk_res(ST_ACCEPT, TK_COMMENT, 1'b1);
        end else begin
          mode_nxt = M_CMT;
        end
      end
      default: begin
        mode_nxt = M_IDLE;
      end
    endcase

    if (res_valid) begin
      mode_nxt = M_IDLE;
    end

    out_valid_nxt = out_valid_r;
    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    if (go && res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_IDLE;
      kinds_r     <= '0;
      brace_r     <= 1'b0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (go) begin
        mode_r  <= mode_nxt;
        kinds_r <= kinds_nxt;
        brace_r <= brace_nxt;
        depth_r <= depth_nxt;
      end
    end
    if (go && res_valid) begin
      out_item_r <= res;
    end
  end

  `TSCL_ASSERT_IMP(a_cmt_depth_nonzero, (mode_r == M_CMT || mode_r == M_CSLASH || mode_r == M_CSTAR), (depth_r != '0), "comment mode with zero nesting depth")
  `TSCL_ASSERT_NXT(a_result_ends_scan, (go && res_valid), (mode_r == M_IDLE && out_valid_r), "scan still running after its result")
  `TSCL_ASSERT_IMP(a_overflow_is_comment, (out_valid_r && out_item_r.status == ST_OVERFLOW), (out_item_r.token_kind == TK_COMMENT && out_item_r.taken), "overflow result not a taken comment")
  `TSCL_ASSERT_IMP(a_reject_kind, (out_valid_r && out_item_r.status == ST_REJECT), (out_item_r.token_kind == TK_STRING), "reject carries a token kind")

endmodule

// ===== sv/template_string_comment_lexer.sv =====
`timescale 1ns / 1ps

// Character-serial lexer for quoted strings with dollar-brace holes, template
// text resumed after a closing brace, and nestable slash-star block comments.
// Characters enter one per transfer on the input queue port; a character with
// start_req set latches the acceptable token kinds and begins a scan, and the
// character that ends a scan yields exactly one result (status, token kind and
// whether that character was taken) on the output queue port. The block takes
// one character per clock cycle while the result register is free or being
// popped, because the back end computes the next scan mode and nesting depth
// for a character combinationally. The character that ends a scan passes the
// front stage register and a queue slot before its result is registered. The
// front end registers and classifies each character, a four-entry queue lets
// the two ends stall independently, and a single result register holds each
// result until it is popped; the back end takes no new character while a
// result waits and is not being popped. No clearing pass is needed after reset.
module template_string_comment_lexer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  tscl_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output tscl_pkg::out_item_t out_item
);
  import tscl_pkg::*;

  // Classified characters travel from the front to the back through the queue.
  logic    q_wr;
  logic    q_full;
  q_item_t q_wr_item;
  logic    q_rd;
  logic    q_nonempty;
  q_item_t q_rd_item;

  tscl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_wr    (q_wr),
    .q_item  (q_wr_item),
    .q_full  (q_full)
  );

  tscl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wr_item  (q_wr_item),
    .full     (q_full),
    .rd       (q_rd),
    .rd_item  (q_rd_item),
    .nonempty (q_nonempty)
  );

  // The back end holds the scan state and the result register.
  tscl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_item     (q_rd_item),
    .q_rd       (q_rd),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_item   (out_item)
  );

endmodule

// ===== tb/sv/lexer_scoreboard_pkg.sv =====
`timescale 1ns / 1ps

package lexer_tb_pkg;

  import tscl_pkg::*;

  // Scan modes of the lexer as the scoreboard tracks them.
  typedef enum {
    LX_IDLE,
    LX_SKIP,
    LX_BODY,
    LX_ESC,
    LX_DOLLAR,
    LX_COPEN,
    LX_CMT,
    LX_CSLASH,
    LX_CSTAR
  } lex_mode_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [4:0] KM_STRING  = 5'b1 << KB_STRING;
  localparam logic [4:0] KM_HEAD    = 5'b1 << KB_HEAD;
  localparam logic [4:0] KM_SPAN    = 5'b1 << KB_SPAN;
  localparam logic [4:0] KM_TAIL    = 5'b1 << KB_TAIL;
  localparam logic [4:0] KM_COMMENT = 5'b1 << KB_COMMENT;
  localparam logic [4:0] KM_ALL     = 5'h1F;

  class lexer_scoreboard;
    lex_mode_t             mode;
    logic [4:0]            kinds;
    bit                    by_brace;
    logic [DEPTH_BITS-1:0] depth;
    out_item_t             want_q[$];
    int                    n_errors;
    int                    n_chars;
    int                    n_live;
    int                    n_checked;
    int                    n_status[4];
    int                    n_kind[8];

    function new();
      mode     = LX_IDLE;
      kinds    = '0;
      by_brace = 1'b0;
      depth    = '0;
    endfunction

    function bit busy();
      return mode != LX_IDLE;
    endfunction

    function bit close_scan(output out_item_t r, input logic [1:0] st,
                            input logic [2:0] tk, input bit tk_taken);
      r.status     = st;
      r.token_kind = tk;
      r.taken      = tk_taken;
      mode         = LX_IDLE;
      return 1'b1;
    endfunction

    // Advances the scan by one character; returns 1 when the scan ends here.
    function bit lex_char(input in_item_t it, output out_item_t r);
      bit         eof;
      logic [7:0] c;
      bit         again;
      bit         hit;
      eof = it.end_of_input;
      c   = it.ch;
      hit = 1'b0;
      r   = '0;
      if (it.start_req) begin
        kinds    = it.valid_kinds;
        by_brace = 1'b0;
        depth    = '0;
        if (it.valid_kinds == '0)
          return close_scan(r, ST_REJECT, TK_STRING, 1'b0);
        mode = LX_SKIP;
      end
      do begin
        again = 1'b0;
        case (mode)
          LX_SKIP: begin
            if (eof)
              hit = close_scan(r, ST_REJECT, TK_STRING, 1'b0);
            else if (c == CH_SP || c == CH_TAB || c == CH_NL || c == CH_CR)
              hit = 1'b0;
            else if (c == CH_RBRACE && (kinds[KB_SPAN] || kinds[KB_TAIL])) begin
              by_brace = 1'b1;
              mode     = LX_BODY;
            end else if (c == CH_QUOTE && (kinds[KB_STRING] || kinds[KB_HEAD])) begin
              by_brace = 1'b0;
              mode     = LX_BODY;
            end else if (c == CH_SLASH && kinds[KB_COMMENT])
              mode = LX_COPEN;
            else
              hit = close_scan(r, ST_REJECT, TK_STRING, 1'b0);
          end
          LX_BODY: begin
            if (eof || c == CH_NL)
              hit = close_scan(r, ST_REJECT, TK_STRING, 1'b0);
            else if (c == CH_BSLASH)
              mode = LX_ESC;
            else if (c == CH_QUOTE) begin
              if (by_brace)
                hit = close_scan(r, ST_ACCEPT, TK_TAIL, 1'b1);
              else if (kinds[KB_STRING])
                hit = close_scan(r, ST_ACCEPT, TK_STRING, 1'b1);
              else
                hit = close_scan(r, ST_REJECT, TK_STRING, 1'b1);
            end else if (c == CH_DOLLAR)
              mode = LX_DOLLAR;
          end
          LX_ESC: begin
            if (eof)
              hit = close_scan(r, ST_REJECT, TK_STRING, 1'b0);
            else
              mode = LX_BODY;
          end
          LX_DOLLAR: begin
            if (!eof && c == CH_LBRACE) begin
              if (by_brace)
                hit = close_scan(r, ST_ACCEPT, TK_SPAN, 1'b1);
              else if (kinds[KB_HEAD])
                hit = close_scan(r, ST_ACCEPT, TK_HEAD, 1'b1);
              else
                hit = close_scan(r, ST_REJECT, TK_STRING, 1'b1);
            end else begin
              // A lone dollar is plain text; look at this character again.
              mode  = LX_BODY;
              again = 1'b1;
            end
          end
          LX_COPEN: begin
            if (!eof && c == CH_STAR) begin
              depth = DEPTH_BITS'(1);
              mode  = LX_CMT;
            end else
              hit = close_scan(r, ST_REJECT, TK_STRING, 1'b0);
          end
          LX_CMT: begin
            if (eof)
              hit = close_scan(r, ST_REJECT, TK_STRING, 1'b0);
            else if (c == CH_SLASH)
              mode = LX_CSLASH;
            else if (c == CH_STAR)
              mode = LX_CSTAR;
          end
          LX_CSLASH: begin
            if (!eof && c == CH_STAR) begin
              if (depth == '1)
                hit = close_scan(r, ST_OVERFLOW, TK_COMMENT, 1'b1);
              else begin
                depth = depth + 1'b1;
                mode  = LX_CMT;
              end
            end else begin
              mode  = LX_CMT;
              again = 1'b1;
            end
          end
          LX_CSTAR: begin
            if (!eof && c == CH_SLASH) begin
              depth = depth - 1'b1;
              if (depth == '0)
                hit = close_scan(r, ST_ACCEPT, TK_COMMENT, 1'b1);
              else
                mode = LX_CMT;
            end else begin
              mode  = LX_CMT;
              again = 1'b1;
            end
          end
          default: hit = 1'b0;
        endcase
      end while (again);
      return hit;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      n_chars++;
      if (it.start_req || mode != LX_IDLE)
        n_live++;
      if (lex_char(it, r))
        want_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (want_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing expected: status %0d kind %0d taken %0d",
                 $time, got.status, got.token_kind, got.taken);
        return;
      end
      want = want_q.pop_front();
      n_checked++;
      n_status[want.status]++;
      if (want.status == ST_ACCEPT)
        n_kind[want.token_kind]++;
      if (got.status !== want.status) begin
        n_errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, got.status);
      end
      if (got.token_kind !== want.token_kind) begin
        n_errors++;
        $display("%0t: token_kind mismatch, expected %0d, actual %0d",
                 $time, want.token_kind, got.token_kind);
      end
      if (got.taken !== want.taken) begin
        n_errors++;
        $display("%0t: taken mismatch, expected %0d, actual %0d",
                 $time, want.taken, got.taken);
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  import tscl_pkg::*;
  import lexer_tb_pkg::*;

  // Shapes of the random tokens that the stimulus builds.
  localparam int SH_QUOTE   = 0;
  localparam int SH_BRACE   = 1;
  localparam int SH_COMMENT = 2;

  // Number of live characters in the random part.
  localparam int RANDOM_CHARS = 500;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_push   = 1'b0;
  logic      in_full;
  in_item_t  in_item   = '0;
  logic      out_empty;
  logic      out_pop   = 1'b0;
  out_item_t out_item;

  // While calm is set, both sides run back to back without idle cycles.
  bit calm = 1'b0;

  lexer_scoreboard sb;

  template_string_comment_lexer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic in_item_t mk_item(bit st, logic [4:0] k, logic [7:0] c, bit e);
    in_item_t it;
    it.start_req    = st;
    it.valid_kinds  = k;
    it.ch           = c;
    it.end_of_input = e;
    return it;
  endfunction

  // Characters for string and comment bodies. The special characters are
  // heavily weighted so that escapes, holes and nesting come up often; now
  // and then any byte at all is used so that every bit of ch toggles.
  function automatic logic [7:0] body_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 40) return CH_BSLASH;
    if (r < 50) return CH_DOLLAR;
    if (r < 57) return CH_LBRACE;
    if (r < 62) return CH_RBRACE;
    if (r < 67) return CH_QUOTE;
    if (r < 75) return CH_SLASH;
    if (r < 83) return CH_STAR;
    if (r < 88) return CH_SP;
    if (r < 90) return CH_NL;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0:       return CH_SP;
      1:       return CH_TAB;
      2:       return CH_NL;
      default: return CH_CR;
    endcase
  endfunction

  // Offers one character and returns at the edge of its transfer. The caller
  // always enters just after the clock rises, so push is only ever lowered and
  // raised in different time steps. in_full is read just after the edge and
  // so still holds the value that the edge itself saw.
  task automatic push_char(input in_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_input(it);
  endtask

  // Sends a text; only its first character may carry the start flag.
  task automatic send_text(input string s, input logic [4:0] kinds, input bit with_start);
    for (int i = 0; i < s.len(); i++)
      push_char(mk_item(with_start && i == 0, kinds, s[i], 1'b0));
  endtask

  task automatic send_eof();
    push_char(mk_item(1'b0, KM_ALL, 8'hFF, 1'b1));
  endtask

  // A random character with rare stray start flags and end-of-input marks,
  // which cut scans short in every mode.
  task automatic push_noisy(input logic [7:0] c, input bit st, input logic [4:0] kinds);
    in_item_t it;
    it.start_req    = st | ($urandom_range(0, 49) == 0);
    it.valid_kinds  = st ? kinds : 5'($urandom_range(0, 31));
    it.ch           = c;
    it.end_of_input = ($urandom_range(0, 49) == 0);
    push_char(it);
  endtask

  // One random token: a few blanks, an opener, a random body, and then
  // closers until the scan ends. Most tokens are well formed, so the scan
  // gets past the opener and into escapes, holes and nested comments.
  task automatic send_token();
    logic [4:0] kinds;
    logic [7:0] plan[$];
    int         shape;
    int         guard;
    calm  = ($urandom_range(0, 4) == 0);
    shape = $urandom_range(0, 2);
    kinds = ($urandom_range(0, 19) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
    if (kinds != 5'd0 && $urandom_range(0, 9) < 8) begin
      case (shape)
        SH_QUOTE: kinds = kinds | ($urandom_range(0, 1) ? KM_STRING : KM_HEAD);
        SH_BRACE: kinds = kinds | ($urandom_range(0, 1) ? KM_SPAN : KM_TAIL);
        default:  kinds = kinds | KM_COMMENT;
      endcase
    end
    // Now and then a stray character while idle, which must change nothing.
    if ($urandom_range(0, 9) == 0)
      push_char(mk_item(1'b0, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1))));
    repeat ($urandom_range(0, 2)) plan.push_back(blank_char());
    case (shape)
      SH_QUOTE: plan.push_back(CH_QUOTE);
      SH_BRACE: plan.push_back(CH_RBRACE);
      default: begin
        plan.push_back(CH_SLASH);
        plan.push_back(($urandom_range(0, 9) == 0) ? body_char() : CH_STAR);
      end
    endcase
    repeat ($urandom_range(0, 10)) begin
      if (shape == SH_COMMENT && $urandom_range(0, 3) == 0) begin
        plan.push_back(CH_SLASH);
        plan.push_back(CH_STAR);
      end else
        plan.push_back(body_char());
    end
    for (int i = 0; i < plan.size(); i++)
      push_noisy(plan[i], i == 0, kinds);
    guard = 0;
    while (sb.busy() && guard < 24) begin
      if (shape == SH_COMMENT) begin
        push_noisy(CH_STAR, 1'b0, kinds);
        push_noisy(CH_SLASH, 1'b0, kinds);
      end else if ($urandom_range(0, 4) < 3)
        push_noisy(CH_QUOTE, 1'b0, kinds);
      else begin
        push_noisy(CH_DOLLAR, 1'b0, kinds);
        push_noisy(CH_LBRACE, 1'b0, kinds);
      end
      guard++;
    end
  endtask

  // Result side: pops with random idle cycles before each transfer and hands
  // every popped result to the scoreboard. out_empty and out_item are read
  // just after the edge, so they hold the values that the edge saw.
  initial begin : result_sink
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      sb.check_result(out_item);
    end
  end

  initial begin : stimulus
    int live_goal;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // A start with no acceptable kinds rejects at once.
    push_char(mk_item(1'b1, 5'd0, CH_QUOTE, 1'b0));
    // Characters while idle are ignored, whatever they hold.
    push_char(mk_item(1'b0, KM_ALL, 8'h00, 1'b0));
    push_char(mk_item(1'b0, 5'd0, 8'hFF, 1'b1));
    // Leading blanks, then a string with an escaped quote.
    send_text(" \t\n\"a\\\"b\"", KM_STRING, 1'b1);
    // A carriage return as a blank, and lone dollars as plain text.
    push_char(mk_item(1'b1, KM_STRING, CH_CR, 1'b0));
    send_text("\"$a$$x\"", KM_STRING, 1'b0);
    // Template head after a run of dollars, and both mismatched ends.
    send_text("\"h$${", KM_HEAD, 1'b1);
    send_text("\"s${", KM_STRING, 1'b1);
    send_text("\"t\"", KM_HEAD, 1'b1);
    // Text resumed after a closing brace ends as a span or a tail, and
    // neither end looks at the latched kinds.
    send_text("}m${", KM_SPAN, 1'b1);
    send_text("}\\n\"", KM_TAIL, 1'b1);
    // Nested comments, one with an opener right after the first opener.
    send_text("/* a /* b */ */", KM_COMMENT, 1'b1);
    send_text("/*/**/*/", KM_COMMENT, 1'b1);
    // A slash that is not followed by a star.
    send_text("/x", KM_COMMENT, 1'b1);
    // A newline inside a string.
    send_text("\"a\n", KM_STRING | KM_HEAD, 1'b1);
    // End of input in body, escape, dollar, comment, opener and skip modes.
    send_text("\"", KM_STRING, 1'b1);
    send_eof();
    send_text("\"\\", KM_STRING, 1'b1);
    send_eof();
    send_text("\"$", KM_HEAD, 1'b1);
    send_eof();
    send_text("/* x", KM_COMMENT, 1'b1);
    send_eof();
    send_text("/", KM_COMMENT, 1'b1);
    send_eof();
    send_text(" ", KM_ALL, 1'b1);
    send_eof();
    push_char(mk_item(1'b1, KM_ALL, 8'hFF, 1'b1));
    // Openers whose kind is not acceptable.
    push_char(mk_item(1'b1, KM_COMMENT, CH_QUOTE, 1'b0));
    push_char(mk_item(1'b1, KM_STRING | KM_HEAD, CH_RBRACE, 1'b0));
    // A new start drops the running scan without a result.
    send_text("\"abc", KM_STRING, 1'b1);
    send_text("\"d\"", KM_STRING, 1'b1);

    // Random tokens until enough characters have gone through live scans.
    live_goal = sb.n_live + RANDOM_CHARS;
    while (sb.n_live < live_goal)
      send_token();
    calm = 1'b0;
    in_push <= 1'b0;

    // Drain, then leave time for any result that should not be there.
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d character transfers (%0d in scans) and %0d checked results.",
             sb.n_chars, sb.n_live, sb.n_checked);
    $display("Accepted %0d (string %0d, head %0d, span %0d, tail %0d, comment %0d), %s%0d, %s%0d.",
             sb.n_status[ST_ACCEPT], sb.n_kind[TK_STRING], sb.n_kind[TK_HEAD],
             sb.n_kind[TK_SPAN], sb.n_kind[TK_TAIL], sb.n_kind[TK_COMMENT],
             "rejected ", sb.n_status[ST_REJECT], "overflow ", sb.n_status[ST_OVERFLOW]);
    if (sb.n_errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Safety net: ends a run that hangs.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d results still expected.", sb.want_q.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== template_string_comment_lexer.f =====
+incdir+sv
sv/tscl_pkg.sv
sv/tscl_front.sv
sv/tscl_queue.sv
sv/tscl_back.sv
sv/template_string_comment_lexer.sv
tb/sv/lexer_scoreboard_pkg.sv
tb/sv/tb_top.sv
